@@ src/wsrx_pkg.sv @@
// Shared types, codes and constants of the WebSocket receive deframer.
// Used by every module in src; depends on nothing.
`default_nettype none

package wsrx_pkg;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned LEN_W = 64;

	localparam logic [CFG_W-1:0] MAX_FRAME_RST = 32'd1048576;
	localparam logic [CFG_W-1:0] MAX_MSG_RST   = 32'd4194304;

	typedef enum logic [0:0] {
		CFG_MAX_FRAME = 1'b0,
		CFG_MAX_MSG   = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_DEAD    = 3'd4
	} phase_t;

	// Header byte fields.
	localparam logic [7:0] FIN_MASK   = 8'h80;
	localparam logic [7:0] RSV_MASK   = 8'h70;
	localparam logic [7:0] OPC_MASK   = 8'h0F;
	localparam logic [7:0] LEN7_MASK  = 8'h7F;
	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;
	localparam logic [3:0] EXT_BYTES16 = 4'd2;
	localparam logic [3:0] EXT_BYTES64 = 4'd8;
	localparam logic [LEN_W-1:0] CTL_MAX_LEN = 64'd125;
	localparam logic [3:0] OPC_CTL_BIT = 4'h8;

	// Opcodes.
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// Frame kinds on the result.
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_BIN   = 2'd1;
	localparam logic [1:0] KIND_PING  = 2'd2;
	localparam logic [1:0] KIND_CLOSE = 2'd3;

	// Error codes.
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_RESERVED  = 4'd1;
	localparam logic [3:0] ERR_MASKED    = 4'd2;
	localparam logic [3:0] ERR_FRAME_BIG = 4'd3;
	localparam logic [3:0] ERR_CTL_LONG  = 4'd4;
	localparam logic [3:0] ERR_CTL_FRAG  = 4'd5;
	localparam logic [3:0] ERR_OPCODE    = 4'd6;
	localparam logic [3:0] ERR_OVERLAP   = 4'd7;
	localparam logic [3:0] ERR_ORPHAN    = 4'd8;
	localparam logic [3:0] ERR_MSG_BIG   = 4'd9;

	// Close payload position, saturating after the status bytes.
	localparam logic [1:0] IDX_FIRST = 2'd0;
	localparam logic [1:0] IDX_SECOND = 2'd1;
	localparam logic [1:0] IDX_REST  = 2'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        has_data;
		logic [1:0]  frame_kind;
		logic        frame_last;
		logic        message_last;
		logic [15:0] status_code;
		logic [3:0]  error_code;
	} result_t;

	function automatic logic [1:0] kind_of(input logic [3:0] opcode, input logic msg_bin);
		logic [1:0] k;
		if (opcode == OP_PING) begin
			k = KIND_PING;
		end else if (opcode == OP_CLOSE) begin
			k = KIND_CLOSE;
		end else if (opcode == OP_PONG) begin
			k = KIND_TEXT;
		end else begin
			k = msg_bin ? KIND_BIN : KIND_TEXT;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

@@ src/wsrx_in_stage.sv @@
// Input register stage of the WebSocket receive deframer.
// Holds one received byte until the parser can take it; uses wsrx_pkg.
`default_nettype none

module wsrx_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] rx_byte,
	output logic            in_stall,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);
	import wsrx_pkg::*;

	// The stage is free when empty or when its item moves on this cycle.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte & 8'hFF;
		end
	end

endmodule

`default_nettype wire

@@ src/wsrx_parser.sv @@
// Frame parser of the WebSocket receive deframer: header state, limit and
// fragmentation checks, configuration registers. Uses wsrx_pkg.
`default_nettype none

module wsrx_parser (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	input  wire logic [7:0]             rx_byte,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [wsrx_pkg::CFG_W-1:0] cfg_data,
	output logic                        res_valid,
	output wsrx_pkg::result_t           res
);
	import wsrx_pkg::*;

	phase_t             phase_q, phase_d;
	logic               fin_q, fin_d;
	logic [3:0]         opcode_q, opcode_d;
	logic [LEN_W-1:0]   flen_q, flen_d;
	logic [3:0]         ext_left_q, ext_left_d;
	logic [LEN_W-1:0]   pay_left_q, pay_left_d;
	logic [1:0]         pay_idx_q, pay_idx_d;
	logic               in_msg_q, in_msg_d;
	logic               msg_bin_q, msg_bin_d;
	logic [LEN_W-1:0]   msg_total_q, msg_total_d;
	logic [15:0]        close_q, close_d;
	logic               rsv_q, rsv_d;
	logic               masked_q, masked_d;
	logic [CFG_W-1:0]   max_frame_q;
	logic [CFG_W-1:0]   max_msg_q;

	logic [6:0]         len7;
	logic [LEN_W-1:0]   msg_sum;

	assign len7 = rx_byte[6:0] & LEN7_MASK[6:0];
	assign msg_sum = msg_total_q + flen_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RST;
			max_msg_q   <= MAX_MSG_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_FRAME: max_frame_q <= cfg_data;
				CFG_MAX_MSG:   max_msg_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			fin_q       <= 1'b0;
			opcode_q    <= 4'h0;
			flen_q      <= '0;
			ext_left_q  <= 4'h0;
			pay_left_q  <= '0;
			pay_idx_q   <= IDX_FIRST;
			in_msg_q    <= 1'b0;
			msg_bin_q   <= 1'b0;
			msg_total_q <= '0;
			close_q     <= 16'h0;
			rsv_q       <= 1'b0;
			masked_q    <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			fin_q       <= fin_d;
			opcode_q    <= opcode_d;
			flen_q      <= flen_d;
			ext_left_q  <= ext_left_d;
			pay_left_q  <= pay_left_d;
			pay_idx_q   <= pay_idx_d;
			in_msg_q    <= in_msg_d;
			msg_bin_q   <= msg_bin_d;
			msg_total_q <= msg_total_d;
			close_q     <= close_d;
			rsv_q       <= rsv_d;
			masked_q    <= masked_d;
		end
	end

	always_comb begin
		logic       hdr_done;
		logic       mask_c;
		logic       ctl;
		logic       last;
		logic [3:0] err;

		phase_d     = phase_q;
		fin_d       = fin_q;
		opcode_d    = opcode_q;
		flen_d      = flen_q;
		ext_left_d  = ext_left_q;
		pay_left_d  = pay_left_q;
		pay_idx_d   = pay_idx_q;
		in_msg_d    = in_msg_q;
		msg_bin_d   = msg_bin_q;
		msg_total_d = msg_total_q;
		close_d     = close_q;
		rsv_d       = rsv_q;
		masked_d    = masked_q;
		res_valid   = 1'b0;
		res         = '0;
		hdr_done    = 1'b0;
		mask_c      = masked_q;
		ctl         = |(opcode_q & OPC_CTL_BIT);
		last        = 1'b0;
		err         = ERR_NONE;

		if (item_valid) begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_d    = |(rx_byte & FIN_MASK);
					rsv_d    = |(rx_byte & RSV_MASK);
					opcode_d = rx_byte[3:0] & OPC_MASK[3:0];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = |(rx_byte & FIN_MASK);
					if (len7 == LEN_CODE16 || len7 == LEN_CODE64) begin
						ext_left_d = (len7 == LEN_CODE16) ? EXT_BYTES16 : EXT_BYTES64;
						flen_d     = '0;
						phase_d    = PH_EXT;
					end else begin
						flen_d   = {{(LEN_W-7){1'b0}}, len7};
						mask_c   = masked_d;
						hdr_done = 1'b1;
					end
				end
				PH_EXT: begin
					flen_d     = {flen_q[LEN_W-9:0], rx_byte};
					ext_left_d = ext_left_q - 4'd1;
					hdr_done   = (ext_left_q == 4'd1);
				end
				PH_PAYLOAD: begin
					pay_left_d = pay_left_q - 64'd1;
					last       = (pay_left_q == 64'd1);
					if (last) begin
						phase_d = PH_HDR0;
					end
					if (pay_idx_q != IDX_REST) begin
						pay_idx_d = pay_idx_q + 2'd1;
					end
					if (opcode_q != OP_PONG) begin
						res_valid          = 1'b1;
						res.data_byte      = rx_byte;
						res.has_data       = 1'b1;
						res.frame_kind     = kind_of(opcode_q, msg_bin_q);
						res.frame_last     = last;
						res.message_last   = last && (ctl || fin_q);
						if (opcode_q == OP_CLOSE) begin
							if (pay_idx_q == IDX_FIRST) begin
								close_d = {rx_byte, 8'h00};
							end else if (pay_idx_q == IDX_SECOND) begin
								close_d = {close_q[15:8], rx_byte};
							end
							if (pay_idx_q != IDX_FIRST) begin
								res.status_code = close_d;
							end
						end
					end
				end
				default: ;
			endcase

			// All header checks are decided when the last length byte arrives.
			if (hdr_done) begin
				if (rsv_q) begin
					err = ERR_RESERVED;
				end else if (mask_c) begin
					err = ERR_MASKED;
				end else if (flen_d > {{(LEN_W-CFG_W){1'b0}}, max_frame_q}) begin
					err = ERR_FRAME_BIG;
				end else if (ctl && flen_d > CTL_MAX_LEN) begin
					err = ERR_CTL_LONG;
				end else if (ctl && !fin_q) begin
					err = ERR_CTL_FRAG;
				end else begin
					case (opcode_q) inside
						OP_CLOSE, OP_PING, OP_PONG: ;
						OP_TEXT, OP_BIN: begin
							if (in_msg_q) begin
								err = ERR_OVERLAP;
							end else if (!fin_q &&
								flen_d > {{(LEN_W-CFG_W){1'b0}}, max_msg_q}) begin
								err = ERR_MSG_BIG;
							end else begin
								in_msg_d    = !fin_q;
								msg_bin_d   = (opcode_q == OP_BIN);
								msg_total_d = flen_d;
							end
						end
						OP_CONT: begin
							if (!in_msg_q) begin
								err = ERR_ORPHAN;
							end else if (msg_sum > {{(LEN_W-CFG_W){1'b0}}, max_msg_q}) begin
								err = ERR_MSG_BIG;
							end else begin
								msg_total_d = msg_sum;
								if (fin_q) begin
									in_msg_d = 1'b0;
								end
							end
						end
						default: err = ERR_OPCODE;
					endcase
				end

				if (err != ERR_NONE) begin
					// Fatal: report once, then ignore the stream until reset.
					phase_d        = PH_DEAD;
					res_valid      = 1'b1;
					res.error_code = err;
				end else begin
					if (opcode_q == OP_CLOSE) begin
						in_msg_d = 1'b0;
						close_d  = 16'h0;
					end
					pay_left_d = flen_d;
					pay_idx_d  = IDX_FIRST;
					if (flen_d == '0) begin
						phase_d = PH_HDR0;
						if (opcode_q != OP_PONG) begin
							res_valid        = 1'b1;
							res.frame_kind   = kind_of(opcode_q, msg_bin_d);
							res.frame_last   = 1'b1;
							res.message_last = ctl || fin_q;
						end
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/wsrx_out_reg.sv @@
// Result register of the WebSocket receive deframer.
// Holds one result item until the receiver takes it; uses wsrx_pkg.
`default_nettype none

module wsrx_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              res_valid,
	input  wire wsrx_pkg::result_t res,
	input  wire logic              out_stall,
	output logic                   advance,
	output logic                   out_valid,
	output wsrx_pkg::result_t      res_q
);
	import wsrx_pkg::*;

	// The register can be loaded when it is empty or being emptied now.
	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= item_valid && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ src/websocket_rx_deframer_top.sv @@
// Top level of the WebSocket receive deframer (server-to-client frames).
// Instantiates wsrx_in_stage, wsrx_parser and wsrx_out_reg; uses wsrx_pkg.
//
// Usage: received stream bytes enter on rx_byte with in_valid; a byte is taken
// at a clock edge where in_valid is high and in_stall is low. Result items leave
// on the payload ports with out_valid and are taken when out_stall is low.
// Each byte yields zero or one item: a payload byte, an empty-frame marker, or
// a single error item, after which all bytes are swallowed until reset.
// A taken byte is held in the input register; the parse logic then loads its
// item into the result register, from which it drives the outputs. One byte
// per clock is sustained while out_stall is low; the rate is set by the single
// parse step between the two registers, which also updates the frame and
// message state. When the receiver holds out_stall with a result waiting, the
// byte in the input register waits and in_stall rises, so at most one extra
// byte is held. Reset (arst_n low) clears the parse state and the open message
// and restores max_frame_len to 1048576 and max_message_len to 4194304. The
// limits are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, as the block does not enforce it.
`default_nettype none

module websocket_rx_deframer_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      data_byte,
	output logic                            has_data,
	output logic [1:0]                      frame_kind,
	output logic                            frame_last,
	output logic                            message_last,
	output logic [15:0]                     status_code,
	output logic [3:0]                      error_code,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [wsrx_pkg::CFG_W-1:0] cfg_data
);
	import wsrx_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	wsrx_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.in_stall (in_stall),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsrx_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1 && advance),
		.rx_byte    (byte_s1),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res        (res)
	);

	wsrx_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.res_valid  (res_valid),
		.res        (res),
		.out_stall  (out_stall),
		.advance    (advance),
		.out_valid  (out_valid),
		.res_q      (res_q)
	);

	assign data_byte    = res_q.data_byte;
	assign has_data     = res_q.has_data;
	assign frame_kind   = res_q.frame_kind;
	assign frame_last   = res_q.frame_last;
	assign message_last = res_q.message_last;
	assign status_code  = res_q.status_code;
	assign error_code   = res_q.error_code;

endmodule

`default_nettype wire

@@ test/tb_websocket_rx_deframer_top.sv @@
// Self-checking testbench for websocket_rx_deframer_top: random frame streams, own predictor.
// Depends on wsrx_pkg and the deframer RTL in src; needs nothing else.

module tb_websocket_rx_deframer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wsrx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 200;

	// Predicts the deframer item by item and checks what comes out against it.
	class deframer_scoreboard;
		logic [31:0] lim_frame;
		logic [31:0] lim_msg;
		phase_t      ph;
		bit          fin, rsv, masked, in_msg, msg_bin;
		logic [3:0]  opc;
		logic [3:0]  ext_left;
		logic [63:0] flen, pay_left, msg_total;
		logic [15:0] close_st;
		result_t     expected_items[$];
		int unsigned n_errors;
		int unsigned n_checked;

		function new();
			lim_frame = MAX_FRAME_RST;
			lim_msg = MAX_MSG_RST;
			ph = PH_HDR0;
			fin = 0;
			rsv = 0;
			masked = 0;
			in_msg = 0;
			msg_bin = 0;
			opc = OP_CONT;
			ext_left = '0;
			flen = '0;
			pay_left = '0;
			msg_total = '0;
			close_st = '0;
			n_errors = 0;
			n_checked = 0;
		endfunction

		function void set_limit(cfg_idx_t idx, logic [31:0] val);
			if (idx == CFG_MAX_FRAME) begin
				lim_frame = val;
			end else begin
				lim_msg = val;
			end
		endfunction

		function int pending();
			return expected_items.size();
		endfunction

		function logic [1:0] kind_now();
			case (opc)
				OP_PING: return KIND_PING;
				OP_CLOSE: return KIND_CLOSE;
				OP_PONG: return KIND_TEXT;
				default: return msg_bin ? KIND_BIN : KIND_TEXT;
			endcase
		endfunction

		// All limit and sequencing checks are decided here, once the length is known.
		function bit header_done(output result_t r);
			logic [3:0] err;
			bit ctl;
			err = ERR_NONE;
			ctl = (opc & OPC_CTL_BIT) != 0;
			r = '0;
			if (rsv) err = ERR_RESERVED;
			else if (masked) err = ERR_MASKED;
			else if (flen > {32'd0, lim_frame}) err = ERR_FRAME_BIG;
			else if (ctl && flen > CTL_MAX_LEN) err = ERR_CTL_LONG;
			else if (ctl && !fin) err = ERR_CTL_FRAG;
			else if (opc == OP_TEXT || opc == OP_BIN) begin
				if (in_msg) err = ERR_OVERLAP;
				else if (!fin && flen > {32'd0, lim_msg}) err = ERR_MSG_BIG;
				else begin
					in_msg = !fin;
					msg_bin = (opc == OP_BIN);
					msg_total = flen;
				end
			end else if (opc == OP_CONT) begin
				if (!in_msg) err = ERR_ORPHAN;
				else if (msg_total + flen > {32'd0, lim_msg}) err = ERR_MSG_BIG;
				else begin
					msg_total = msg_total + flen;
					if (fin) in_msg = 0;
				end
			end else if (opc != OP_CLOSE && opc != OP_PING && opc != OP_PONG) begin
				err = ERR_OPCODE;
			end

			if (err != ERR_NONE) begin
				ph = PH_DEAD;
				r.error_code = err;
				return 1;
			end
			if (opc == OP_CLOSE) begin
				in_msg = 0;
				close_st = '0;
			end
			pay_left = flen;
			if (flen == 0) begin
				ph = PH_HDR0;
				if (opc == OP_PONG) return 0;
				r.frame_kind = kind_now();
				r.frame_last = 1'b1;
				r.message_last = ctl || fin;
				return 1;
			end
			ph = PH_PAYLOAD;
			return 0;
		endfunction

		function void note_byte(logic [7:0] b);
			result_t r;
			bit got;
			bit ctl;
			logic [63:0] pos;
			got = 0;
			r = '0;
			case (ph)
				PH_HDR0: begin
					fin = (b & FIN_MASK) != 0;
					rsv = (b & RSV_MASK) != 0;
					opc = b[3:0];
					ph = PH_HDR1;
				end
				PH_HDR1: begin
					masked = (b & FIN_MASK) != 0;
					if (b[6:0] == LEN_CODE16 || b[6:0] == LEN_CODE64) begin
						ext_left = (b[6:0] == LEN_CODE16) ? EXT_BYTES16 : EXT_BYTES64;
						flen = '0;
						ph = PH_EXT;
					end else begin
						flen = 64'(b & LEN7_MASK);
						got = header_done(r);
					end
				end
				PH_EXT: begin
					flen = {flen[55:0], b};
					ext_left = ext_left - 4'd1;
					if (ext_left == 0) got = header_done(r);
				end
				PH_PAYLOAD: begin
					pos = flen - pay_left;
					ctl = (opc & OPC_CTL_BIT) != 0;
					if (pay_left != 0) pay_left = pay_left - 1;
					if (pay_left == 0) ph = PH_HDR0;
					if (opc != OP_PONG) begin
						if (opc == OP_CLOSE) begin
							if (pos == 0) close_st = {b, 8'h00};
							else if (pos == 1) close_st[7:0] = b;
							if (pos >= 1) r.status_code = close_st;
						end
						r.data_byte = b;
						r.has_data = 1'b1;
						r.frame_kind = kind_now();
						r.frame_last = (pay_left == 0);
						r.message_last = (pay_left == 0) && (ctl || fin);
						got = 1;
					end
				end
				default: ;
			endcase
			if (got) expected_items.insert(expected_items.size(), r);
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			n_errors++;
			$display("[%0t] item %0d %s: got 0x%0h, expected 0x%0h",
				$time, n_checked, what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			n_checked++;
			if (expected_items.size() == 0) begin
				report_mismatch("arrived with nothing expected", got, 0);
				return;
			end
			want = expected_items.pop_front();
			if (got.data_byte != want.data_byte)
				report_mismatch("data_byte", got.data_byte, want.data_byte);
			if (got.has_data != want.has_data)
				report_mismatch("has_data", got.has_data, want.has_data);
			if (got.frame_kind != want.frame_kind)
				report_mismatch("frame_kind", got.frame_kind, want.frame_kind);
			if (got.frame_last != want.frame_last)
				report_mismatch("frame_last", got.frame_last, want.frame_last);
			if (got.message_last != want.message_last)
				report_mismatch("message_last", got.message_last, want.message_last);
			if (got.status_code != want.status_code)
				report_mismatch("status_code", got.status_code, want.status_code);
			if (got.error_code != want.error_code)
				report_mismatch("error_code", got.error_code, want.error_code);
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic        has_data;
	logic [1:0]  frame_kind;
	logic        frame_last;
	logic        message_last;
	logic [15:0] status_code;
	logic [3:0]  error_code;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_MAX_FRAME;
	logic [CFG_W-1:0] cfg_data = '0;

	websocket_rx_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.has_data(has_data),
		.frame_kind(frame_kind),
		.frame_last(frame_last),
		.message_last(message_last),
		.status_code(status_code),
		.error_code(error_code),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	deframer_scoreboard sb = new();

	logic [7:0]  tx_fifo[$];
	int unsigned bytes_queued = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned total_cyc = 0;
	bit          hold_trigger = 0;
	logic        rx_hold = 1'b0;

	// Stream generator's view of the open message, used to keep frames legal.
	bit          g_in_msg = 0;
	logic [63:0] g_total = '0;
	logic [63:0] g_lim_frame = 64'(MAX_FRAME_RST);
	logic [63:0] g_lim_msg = 64'(MAX_MSG_RST);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		total_cyc++;
		if (total_cyc > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic drive_sender();
		bit taken, offer;
		taken = in_valid && !in_stall;
		if (taken) begin
			sb.note_byte(rx_byte);
			void'(tx_fifo.pop_front());
		end
		if (in_valid && !taken)
			offer = 1;
		else
			offer = (tx_fifo.size() > 0) && !($urandom_range(99) < send_idle_pct);
		in_valid <= offer;
		if (offer) rx_byte <= tx_fifo[0];
	endtask

	task automatic drive_receiver();
		result_t got;
		if (out_valid && !out_stall) begin
			got = {data_byte, has_data, frame_kind, frame_last, message_last,
				status_code, error_code};
			sb.check_result(got);
		end
		out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			drive_sender();
			drive_receiver();
		end
	end

	// Long receiver hold-off so that the block backs up into its input.
	initial begin
		wait (hold_trigger);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic void push_byte(logic [7:0] b);
		tx_fifo.insert(tx_fifo.size(), b);
		bytes_queued++;
	endfunction

	function automatic int pick_enc();
		return ($urandom_range(9) < 2) ? int'($urandom_range(2, 1)) : 0;
	endfunction

	// Mostly short lengths, now and then one past the 7-bit range.
	function automatic logic [63:0] pick_len(logic [63:0] cap);
		logic [63:0] top;
		top = ($urandom_range(15) == 0) ? 64'd300 : 64'd24;
		if (cap < top) top = cap;
		if ($urandom_range(7) == 0) return top;
		return 64'($urandom_range(top[31:0], 0));
	endfunction

	// enc 0 uses the shortest length form, 1 prefers the 16-bit form, 2 forces 64 bits.
	task automatic queue_header(bit fin, logic [2:0] rsv, logic [3:0] opc, bit mask,
			logic [63:0] len, int enc);
		push_byte({fin, rsv, opc});
		if (enc == 0 && len < 64'(LEN_CODE16)) begin
			push_byte({mask, len[6:0]});
		end else if (enc != 2 && len <= 64'hFFFF) begin
			push_byte({mask, LEN_CODE16});
			push_byte(len[15:8]);
			push_byte(len[7:0]);
		end else begin
			push_byte({mask, LEN_CODE64});
			for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
		end
	endtask

	task automatic queue_payload(logic [63:0] n);
		for (longint unsigned i = 0; i < n; i++) push_byte(8'($urandom_range(255)));
	endtask

	task automatic open_message();
		queue_header(1'b0, 3'b000, OP_BIN, 1'b0, 64'd3, 0);
		queue_payload(64'd3);
		g_in_msg = 1;
		g_total = 64'd3;
	endtask

	task automatic queue_random_frame();
		int unsigned pick;
		logic [63:0] len, cap, ctl_cap;
		bit fin;
		logic [3:0] opc;
		pick = $urandom_range(99);
		ctl_cap = min64(CTL_MAX_LEN, g_lim_frame);
		fin = 1'b1;
		if (pick < 12) begin
			opc = OP_PING;
			len = pick_len(ctl_cap);
		end else if (pick < 22) begin
			opc = OP_PONG;
			len = pick_len(ctl_cap);
		end else if (pick < 26) begin
			opc = OP_CLOSE;
			len = pick_len(ctl_cap);
			g_in_msg = 0;
		end else if (g_in_msg) begin
			opc = OP_CONT;
			fin = ($urandom_range(2) == 0);
			len = pick_len(min64(g_lim_frame, g_lim_msg - g_total));
			g_total = g_total + len;
			if (fin) g_in_msg = 0;
		end else begin
			opc = $urandom_range(1) ? OP_BIN : OP_TEXT;
			fin = $urandom_range(1);
			cap = fin ? g_lim_frame : min64(g_lim_frame, g_lim_msg);
			len = pick_len(cap);
			g_in_msg = !fin;
			g_total = len;
		end
		queue_header(fin, 3'b000, opc, 1'b0, len, pick_enc());
		queue_payload(len);
	endtask

	// One protocol violation picked at random; the block goes dead after it.
	task automatic queue_fatal_frame();
		logic [3:0] want_err, opc;
		logic [63:0] len;
		logic [2:0] rsv;
		bit fin, mask;
		want_err = 4'($urandom_range(ERR_MSG_BIG, ERR_RESERVED));
		fin = 1'b1;
		mask = 1'b0;
		rsv = 3'b000;
		opc = OP_TEXT;
		len = pick_len(CTL_MAX_LEN);
		case (want_err)
			ERR_RESERVED: begin
				rsv = 3'($urandom_range(7, 1));
				mask = $urandom_range(1);
			end
			ERR_MASKED: mask = 1'b1;
			ERR_FRAME_BIG: len = ($urandom_range(2) == 0) ? '1 :
				g_lim_frame + 64'd1 + 64'($urandom_range(40));
			ERR_CTL_LONG: begin
				opc = OP_CLOSE + 4'($urandom_range(2));
				len = 64'($urandom_range(400, 126));
			end
			ERR_CTL_FRAG: begin
				opc = OP_CLOSE + 4'($urandom_range(2));
				fin = 1'b0;
			end
			ERR_OPCODE: opc = $urandom_range(1) ? 4'($urandom_range(7, 3)) :
				4'($urandom_range(15, 11));
			ERR_OVERLAP: begin
				if (!g_in_msg) open_message();
				opc = $urandom_range(1) ? OP_BIN : OP_TEXT;
				fin = $urandom_range(1);
			end
			ERR_ORPHAN: begin
				if (g_in_msg) begin
					queue_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd0, 0);
					g_in_msg = 0;
				end
				opc = OP_CONT;
				fin = $urandom_range(1);
			end
			default: begin
				if (g_in_msg || $urandom_range(1)) begin
					if (!g_in_msg) open_message();
					opc = OP_CONT;
					fin = $urandom_range(1);
					len = g_lim_msg - g_total + 64'd1 + 64'($urandom_range(20));
				end else begin
					fin = 1'b0;
					len = g_lim_msg + 64'd1 + 64'($urandom_range(20));
				end
			end
		endcase
		queue_header(fin, rsv, opc, mask, len, int'($urandom_range(2)));
		queue_payload(min64(len, 64'd16));
		queue_payload(64'd24);
	endtask

	task automatic write_limit(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(idx, val);
		if (idx == CFG_MAX_FRAME) g_lim_frame = 64'(val);
		else g_lim_msg = 64'(val);
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 86; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 86; end
			default: begin send_idle_pct = 22; stall_pct = 22; end
		endcase
	endtask

	// Idle means every byte taken and every item out; pong bytes give no item,
	// so the task then waits on so that the last of them clears the pipeline.
	task automatic wait_drained();
		while (tx_fifo.size() != 0 || in_valid || sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [31:0] f, m;
		int unsigned target;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(3);
		// Directed frames at the reset limits.
		queue_header(1'b1, 3'b000, OP_TEXT, 1'b0, 64'd0, 0);
		queue_header(1'b1, 3'b000, OP_BIN, 1'b0, 64'd1, 0);
		push_byte(8'hFF);
		queue_header(1'b1, 3'b000, OP_PONG, 1'b0, 64'd1, 0);
		push_byte(8'h00);
		// A one-byte close carries no status.
		queue_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd1, 0);
		push_byte(8'h5A);
		// Fragmented text with a ping in between, ended by an empty continuation.
		queue_header(1'b0, 3'b000, OP_TEXT, 1'b0, 64'd1, 0);
		push_byte(8'h00);
		queue_header(1'b1, 3'b000, OP_PING, 1'b0, 64'd0, 0);
		queue_header(1'b1, 3'b000, OP_CONT, 1'b0, 64'd0, 0);
		queue_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd2, 1);
		push_byte(8'h03);
		push_byte(8'hE8);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin f = '1; m = '1; end
				1: begin f = '0; m = '0; end
				2: begin f = $urandom_range(60, 1); m = $urandom_range(80); end
				3: begin f = 32'd300; m = 32'd50; end
				4: begin f = MAX_FRAME_RST; m = MAX_MSG_RST; end
				default: begin f = $urandom; m = $urandom_range(5000); end
			endcase
			write_limit(CFG_MAX_FRAME, f);
			write_limit(CFG_MAX_MSG, m);
			@(negedge clk);
			set_idling(ph % 4);
			target = bytes_queued + 210;
			while (bytes_queued < target) queue_random_frame();
			if (ph == 0) hold_trigger = 1;
			// Close any open message so that new limits never break it.
			if (g_in_msg) begin
				queue_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd0, 0);
				g_in_msg = 0;
			end
			wait_drained();
		end

		write_limit(CFG_MAX_FRAME, '1);
		write_limit(CFG_MAX_MSG, $urandom_range(400, 40));
		@(negedge clk);
		set_idling(2);
		target = bytes_queued + 140;
		while (bytes_queued < target) queue_random_frame();
		queue_fatal_frame();
		wait_drained();
		repeat (8) @(posedge clk);

		if (sb.n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
